[hdl/mpq_pkg.sv]
// ----------------------------------------------------------------------------
// mpq_pkg
// Shared constants and types for the min priority queue.
// ----------------------------------------------------------------------------
package mpq_pkg;

    localparam int CAPACITY_DEF = 64;

    localparam int KEY_W   = 32;
    localparam int COUNT_W = 7;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_REMOVE = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DEL_WR,
        ST_SCAN
    } state_t;

endpackage

[hdl/min_priority_queue.sv]
// ----------------------------------------------------------------------------
// min_priority_queue
// Bounded min-priority queue of signed keys kept unordered in one RAM.
// ----------------------------------------------------------------------------
//
//  channel | ports                                        | direction
//  --------+----------------------------------------------+----------
//  input   | s_valid s_ready s_operation s_key            | in
//  result  | m_valid m_ready m_min_key m_nonempty          | out
//          | m_entry_count m_error                        |
//
//  Insert: result in the cycle after the accept. Running minimum and its
//  slot are kept in registers, so an insert only writes the RAM.
//  Remove from two or more keys: the accept cycle reads the last slot, the
//  next cycle moves it into the freed slot, then a rescan reads the r
//  remaining slots at one RAM read per cycle and registers the new minimum
//  as the result. The RAM read port paces the rescan. A remove from one key
//  or none answers as an insert does, with no rescan. One item is in
//  flight at a time; a new item is taken once the previous result has left
//  the output register.
//  Reset (aresetn, synchronous) clears count, state and valid; RAM contents
//  outside the occupied range are never used, so the RAM has no reset.
//
module min_priority_queue #(
    parameter int CAPACITY = mpq_pkg::CAPACITY_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_operation,
    input  logic signed [mpq_pkg::KEY_W-1:0]    s_key,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [mpq_pkg::KEY_W-1:0]    m_min_key,
    output logic                                m_nonempty,
    output logic [mpq_pkg::COUNT_W-1:0]         m_entry_count,
    output logic                                m_error
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] FULL = CW'(CAPACITY);

    // key RAM, one write and one registered read per cycle
    logic signed [mpq_pkg::KEY_W-1:0] mem [CAPACITY];
    logic                             wr_en;
    logic [AW-1:0]                    wr_addr;
    logic signed [mpq_pkg::KEY_W-1:0] wr_data;
    logic [AW-1:0]                    rd_addr;
    logic signed [mpq_pkg::KEY_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    mpq_pkg::state_t state_reg, state_next;
    logic [CW-1:0]   count_reg, count_next;
    logic signed [mpq_pkg::KEY_W-1:0] min_reg, min_next;
    logic [AW-1:0]   min_idx_reg, min_idx_next;
    logic [CW-1:0]   ptr_reg, ptr_next;
    logic            cmp_vld_reg, cmp_vld_next;
    logic [AW-1:0]   cmp_idx_reg, cmp_idx_next;

    logic            out_vld_reg, out_vld_next;
    logic signed [mpq_pkg::KEY_W-1:0] out_key_reg, out_key_next;
    logic            out_ne_reg, out_ne_next;
    logic [CW-1:0]   out_cnt_reg, out_cnt_next;
    logic            out_err_reg, out_err_next;

    logic [CW-1:0]   count_dec;
    logic            accept;
    logic [CW+mpq_pkg::COUNT_W-1:0] cnt_ext;

    assign count_dec = count_reg - CW'(1);
    assign s_ready   = (state_reg == mpq_pkg::ST_IDLE) && !out_vld_reg;
    assign accept    = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= mpq_pkg::ST_IDLE;
            count_reg   <= '0;
            cmp_vld_reg <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            cmp_vld_reg <= cmp_vld_next;
            out_vld_reg <= out_vld_next;
        end
        min_reg     <= min_next;
        min_idx_reg <= min_idx_next;
        ptr_reg     <= ptr_next;
        cmp_idx_reg <= cmp_idx_next;
        out_key_reg <= out_key_next;
        out_ne_reg  <= out_ne_next;
        out_cnt_reg <= out_cnt_next;
        out_err_reg <= out_err_next;
    end

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        min_next     = min_reg;
        min_idx_next = min_idx_reg;
        ptr_next     = ptr_reg;
        cmp_vld_next = 1'b0;
        cmp_idx_next = cmp_idx_reg;
        out_vld_next = out_vld_reg && !m_ready;
        out_key_next = out_key_reg;
        out_ne_next  = out_ne_reg;
        out_cnt_next = out_cnt_reg;
        out_err_next = out_err_reg;
        wr_en        = 1'b0;
        wr_addr      = count_reg[AW-1:0];
        wr_data      = s_key;
        rd_addr      = count_dec[AW-1:0];

        case (state_reg)
            mpq_pkg::ST_IDLE: begin
                if (accept) begin
                    if (s_operation == mpq_pkg::OP_INSERT) begin
                        if (count_reg == FULL) begin
                            // full: key dropped
                            out_vld_next = 1'b1;
                            out_key_next = min_reg;
                            out_ne_next  = 1'b1;
                            out_cnt_next = count_reg;
                            out_err_next = 1'b1;
                        end else begin
                            wr_en      = 1'b1;
                            count_next = count_reg + CW'(1);
                            if (count_reg == '0 || s_key < min_reg) begin
                                min_next     = s_key;
                                min_idx_next = count_reg[AW-1:0];
                            end
                            out_vld_next = 1'b1;
                            out_key_next = (count_reg == '0 || s_key < min_reg)
                                           ? s_key : min_reg;
                            out_ne_next  = 1'b1;
                            out_cnt_next = count_reg + CW'(1);
                            out_err_next = 1'b0;
                        end
                    end else begin
                        if (count_reg == '0) begin
                            // empty: nothing to remove
                            out_vld_next = 1'b1;
                            out_key_next = '0;
                            out_ne_next  = 1'b0;
                            out_cnt_next = '0;
                            out_err_next = 1'b1;
                        end else if (count_reg == CW'(1)) begin
                            count_next   = '0;
                            out_vld_next = 1'b1;
                            out_key_next = '0;
                            out_ne_next  = 1'b0;
                            out_cnt_next = '0;
                            out_err_next = 1'b0;
                        end else begin
                            // read last slot, moved into the freed one next
                            state_next = mpq_pkg::ST_DEL_WR;
                        end
                    end
                end
            end
            mpq_pkg::ST_DEL_WR: begin
                wr_en      = 1'b1;
                wr_addr    = min_idx_reg;
                wr_data    = rd_data_reg;
                count_next = count_dec;
                ptr_next   = '0;
                state_next = mpq_pkg::ST_SCAN;
            end
            mpq_pkg::ST_SCAN: begin
                rd_addr = ptr_reg[AW-1:0];
                if (ptr_reg != count_reg) begin
                    cmp_vld_next = 1'b1;
                    cmp_idx_next = ptr_reg[AW-1:0];
                    ptr_next     = ptr_reg + CW'(1);
                end
                if (cmp_vld_reg) begin
                    if (cmp_idx_reg == '0 || rd_data_reg < min_reg) begin
                        min_next     = rd_data_reg;
                        min_idx_next = cmp_idx_reg;
                    end
                end
                if (ptr_reg == count_reg && !cmp_vld_reg) begin
                    state_next   = mpq_pkg::ST_IDLE;
                    out_vld_next = 1'b1;
                    out_key_next = min_reg;
                    out_ne_next  = 1'b1;
                    out_cnt_next = count_reg;
                    out_err_next = 1'b0;
                end
            end
            default: begin
                state_next = mpq_pkg::ST_IDLE;
            end
        endcase
    end

    // count reported modulo 2**COUNT_W
    assign cnt_ext       = {{mpq_pkg::COUNT_W{1'b0}}, out_cnt_reg};
    assign m_valid       = out_vld_reg;
    assign m_min_key     = out_key_reg;
    assign m_nonempty    = out_ne_reg;
    assign m_entry_count = cnt_ext[mpq_pkg::COUNT_W-1:0];
    assign m_error       = out_err_reg;

endmodule

[hdl/mpq_checker.sv]
// ----------------------------------------------------------------------------
// mpq_checker
// Port-level assertions for min_priority_queue, bound to each of its instances.
// ----------------------------------------------------------------------------
module mpq_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_valid,
    input logic                              s_ready,
    input logic                              m_valid,
    input logic                              m_ready,
    input logic signed [mpq_pkg::KEY_W-1:0]  m_min_key,
    input logic                              m_nonempty,
    input logic [mpq_pkg::COUNT_W-1:0]       m_entry_count,
    input logic                              m_error
);

    // held result does not change
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_min_key)
            && $stable(m_nonempty) && $stable(m_entry_count) && $stable(m_error))
        else $error("result changed while stalled");

    // one item in flight
    a_one_inflight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("item taken while another is in flight");

    a_no_take_with_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready)
        else $error("input ready while result pending");

    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_nonempty |-> m_min_key == '0 && m_entry_count == '0)
        else $error("empty result with nonzero key or count");

endmodule

bind min_priority_queue mpq_checker u_mpq_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_min_key     (m_min_key),
    .m_nonempty    (m_nonempty),
    .m_entry_count (m_entry_count),
    .m_error       (m_error)
);

[bench/min_priority_queue_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// min_priority_queue_tb
// Drives inserts and removals through the input channel, predicts each
// result with a behavioral queue, and checks every result field by field.
// ----------------------------------------------------------------------------
module min_priority_queue_tb;

    localparam int CAP = mpq_pkg::CAPACITY_DEF;

    logic                               aclk = 1'b0;
    logic                               aresetn = 1'b0;
    logic                               s_valid = 1'b0;
    logic                               s_ready;
    logic                               s_operation = 1'b0;
    logic signed [mpq_pkg::KEY_W-1:0]   s_key = '0;
    logic                               m_valid;
    logic                               m_ready = 1'b0;
    logic signed [mpq_pkg::KEY_W-1:0]   m_min_key;
    logic                               m_nonempty;
    logic [mpq_pkg::COUNT_W-1:0]        m_entry_count;
    logic                               m_error;

    typedef struct packed {
        logic signed [mpq_pkg::KEY_W-1:0] min_key;
        logic                             nonempty;
        logic [mpq_pkg::COUNT_W-1:0]      entry_count;
        logic                             error;
    } status_t;

    // Behavioral queue: unordered keys plus count, like the block.
    logic signed [mpq_pkg::KEY_W-1:0] held_keys[$];
    status_t                          pending_status[$];
    int                               fail_count = 0;
    bit                               quiet_mode = 1'b0;   // no idling on either side

    min_priority_queue u_dut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Ends the run if something hangs.
    initial begin
        #20ms;
        $display("** min_priority_queue: FAILED **");
        $finish;
    end

    function automatic int smallest_index();
        int best;
        best = 0;
        for (int i = 1; i < held_keys.size(); i++)
            if (held_keys[i] < held_keys[best]) best = i;
        return best;
    endfunction

    // Update the queue model for one item and push the status it yields.
    function automatic void predict_status(mpq_pkg::op_t op,
                                           logic signed [mpq_pkg::KEY_W-1:0] key);
        status_t st;
        int      m;
        st = '0;
        if (op == mpq_pkg::OP_INSERT) begin
            if (held_keys.size() >= CAP) st.error = 1'b1;
            else held_keys.push_back(key);
        end else begin
            if (held_keys.size() == 0) begin
                st.error = 1'b1;
            end else begin
                // last slot moves into the freed one
                m = smallest_index();
                held_keys[m] = held_keys[held_keys.size()-1];
                void'(held_keys.pop_back());
            end
        end
        if (held_keys.size() > 0) st.min_key = held_keys[smallest_index()];
        st.nonempty    = held_keys.size() > 0;
        st.entry_count = mpq_pkg::COUNT_W'(held_keys.size());
        pending_status.push_back(st);
    endfunction

    // Send one item; valid held with payload stable until accepted.
    task automatic send_item(mpq_pkg::op_t op, logic signed [mpq_pkg::KEY_W-1:0] key);
        while (!quiet_mode && $urandom_range(99) < 9) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_operation <= op;
        s_key       <= key;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_status(op, key);
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (pending_status.size() != 0) @(negedge aclk);
        repeat (CAP + 8) @(negedge aclk);
    endtask

    // Receiver stalls at random.
    always @(negedge aclk)
        m_ready <= quiet_mode ? 1'b1 : ($urandom_range(99) >= 9);

    // Result checker, sampled at the rising edge.
    always @(posedge aclk) begin
        status_t exp_st;
        if (aresetn && m_valid && m_ready) begin
            if (pending_status.size() == 0) begin
                $error("result item with nothing expected");
                fail_count++;
            end else begin
                exp_st = pending_status.pop_front();
                if (m_min_key !== exp_st.min_key) begin
                    $error("min_key expected %0d actual %0d", exp_st.min_key, m_min_key);
                    fail_count++;
                end
                if (m_nonempty !== exp_st.nonempty) begin
                    $error("nonempty expected %0b actual %0b", exp_st.nonempty, m_nonempty);
                    fail_count++;
                end
                if (m_entry_count !== exp_st.entry_count) begin
                    $error("entry_count expected %0d actual %0d",
                           exp_st.entry_count, m_entry_count);
                    fail_count++;
                end
                if (m_error !== exp_st.error) begin
                    $error("error expected %0b actual %0b", exp_st.error, m_error);
                    fail_count++;
                end
            end
        end
    end

    function automatic logic signed [mpq_pkg::KEY_W-1:0] rand_key();
        case ($urandom_range(5))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return mpq_pkg::KEY_W'($urandom_range(8)) - 4;   // dense, many duplicates
            default: return $urandom;
        endcase
    endfunction

    // Edge cases: remove from empty, extreme keys, duplicates, removal past empty.
    task automatic test_directed();
        send_item(mpq_pkg::OP_REMOVE, 32'sh1234_5678);   // removal when empty
        send_item(mpq_pkg::OP_INSERT, 32'sh7fff_ffff);
        send_item(mpq_pkg::OP_INSERT, 32'sh8000_0000);
        send_item(mpq_pkg::OP_INSERT, 32'sh8000_0000);   // duplicate minimum
        send_item(mpq_pkg::OP_INSERT, 32'shffff_ffff);
        send_item(mpq_pkg::OP_INSERT, 32'sh5555_aaaa);
        send_item(mpq_pkg::OP_INSERT, 32'shaaaa_5555);
        send_item(mpq_pkg::OP_REMOVE, '0);
        send_item(mpq_pkg::OP_REMOVE, 32'shffff_ffff);
        for (int i = 0; i < 6; i++) send_item(mpq_pkg::OP_REMOVE, '0);   // run past empty
        send_item(mpq_pkg::OP_INSERT, '0);
        send_item(mpq_pkg::OP_REMOVE, '0);               // empty again: min_key 0
    endtask

    // Fill past capacity so inserts into a full store are seen.
    task automatic test_full_store();
        while (held_keys.size() < CAP + 3) begin
            send_item(mpq_pkg::OP_INSERT, rand_key());
            if (held_keys.size() == CAP) break;
        end
        repeat (4) send_item(mpq_pkg::OP_INSERT, rand_key());
        wait_drained();                         // sender holds off until drained
        repeat (CAP + 4) send_item(mpq_pkg::OP_REMOVE, rand_key());
    endtask

    // Random mix, with the fill level swept between empty and full.
    task automatic test_random_mix(int n_items);
        int bias;
        for (int i = 0; i < n_items; i++) begin
            if (i % 150 == 0) bias = $urandom_range(20, 80);
            quiet_mode = (i >= 400 && i < 550);
            send_item(mpq_pkg::op_t'($urandom_range(99) >= bias), rand_key());
        end
        quiet_mode = 1'b0;
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_directed();
        test_full_store();
        test_random_mix(900);
        wait_drained();
        if (fail_count == 0)
            $display("** min_priority_queue: PASSED **");
        else
            $display("** min_priority_queue: FAILED **");
        $finish;
    end
endmodule

[sim.f]
hdl/mpq_pkg.sv
hdl/min_priority_queue.sv
hdl/mpq_checker.sv
bench/min_priority_queue_tb.sv
